FILE: rtl/assert_macros.svh
// assertion macros used by the top level rtl file
// each macro expects clk and rst to be visible where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/icda_pkg.sv
// types and constants for the interface counter delta accumulator
// used by the channel interfaces, the datapath and the top level
package icda_pkg;

  localparam int NUM_IFACES_DEF = 64;
  localparam int IFACE_W        = 6;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELTA_NARROW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELTA_WIDE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NARROW_START     = 2'd2;

  localparam logic [31:0] MAX_DELTA_NARROW_RST = 32'h1000_0000;
  localparam logic [63:0] MAX_DELTA_WIDE_RST   = 64'h0000_0100_0000_0000;
  localparam logic        NARROW_START_RST     = 1'b1;

  typedef struct packed {
    logic [IFACE_W-1:0] iface;
    logic [63:0]        raw_bytes_rx;
    logic [63:0]        raw_pkts_rx;
    logic [63:0]        raw_errs_rx;
    logic [63:0]        raw_drops_rx;
    logic [63:0]        raw_bytes_tx;
    logic [63:0]        raw_pkts_tx;
    logic [63:0]        raw_errs_tx;
    logic [63:0]        raw_drops_tx;
  } in_item_t;

  typedef struct packed {
    logic [IFACE_W-1:0] iface_out;
    logic [63:0]        total_bytes_rx;
    logic [31:0]        total_pkts_rx;
    logic [31:0]        total_errs_rx;
    logic [31:0]        total_drops_rx;
    logic [63:0]        total_bytes_tx;
    logic [31:0]        total_pkts_tx;
    logic [31:0]        total_errs_tx;
    logic [31:0]        total_drops_tx;
    logic               discontinuity;
    logic               accumulated;
  } out_item_t;

  // one interface entry; byte pairs are rx then tx,
  // small counts are pkts, errs, drops for rx then tx
  typedef struct packed {
    logic             seen;
    logic [1:0][63:0] last_bytes;
    logic [1:0][31:0] last_bytes_low;
    logic [5:0][31:0] last_small;
    logic [1:0][63:0] tot_bytes;
    logic [5:0][31:0] tot_small;
  } entry_t;

  typedef struct packed {
    logic [31:0] max_delta_narrow;
    logic [63:0] max_delta_wide;
    logic        narrow_mode;
  } cfg_t;

endpackage

FILE: rtl/icda_in_if.sv
// counter sample channel: valid, ready and one sample item
// depends on icda_pkg
interface icda_in_if;
  logic               valid;
  logic               ready;
  icda_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

FILE: rtl/icda_out_if.sv
// totals result channel: valid, ready and one result item
// depends on icda_pkg
interface icda_out_if;
  logic                valid;
  logic                ready;
  icda_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

FILE: rtl/icda_cfg_if.sv
// configuration write channel: valid, ready, register index and data
// depends on icda_pkg
interface icda_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [icda_pkg::CFG_IDX_W-1:0]      index;
  logic [icda_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/icda_ram.sv
// generic single write port ram with registered read
// no dependencies
module icda_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/icda_calc.sv
// delta, threshold check and accumulation for one interface entry
// depends on icda_pkg
module icda_calc (
  input  icda_pkg::in_item_t  item,
  input  icda_pkg::entry_t    entry,
  input  icda_pkg::cfg_t      cfg,
  output icda_pkg::entry_t    entry_next,
  output icda_pkg::out_item_t result,
  output logic                narrow_off
);

  logic [1:0][63:0] raw_bytes;
  logic [5:0][31:0] raw_small;
  logic [1:0][63:0] dbytes;
  logic [5:0][31:0] dsmall;
  logic [63:0]      byte_limit;
  logic             over;
  logic             acc;

  always_comb begin
    raw_bytes[0] = item.raw_bytes_rx;
    raw_bytes[1] = item.raw_bytes_tx;
    raw_small[0] = item.raw_pkts_rx[31:0];
    raw_small[1] = item.raw_errs_rx[31:0];
    raw_small[2] = item.raw_drops_rx[31:0];
    raw_small[3] = item.raw_pkts_tx[31:0];
    raw_small[4] = item.raw_errs_tx[31:0];
    raw_small[5] = item.raw_drops_tx[31:0];

    entry_next = entry;
    entry_next.seen = 1'b1;
    entry_next.last_bytes = raw_bytes;
    entry_next.last_small = raw_small;

    for (int k = 0; k < 6; k++) begin
      dsmall[k] = raw_small[k] - entry.last_small[k];
    end

    if (cfg.narrow_mode) begin
      // 32-bit wrapping byte deltas on the low halves
      for (int k = 0; k < 2; k++) begin
        dbytes[k] = {32'd0, raw_bytes[k][31:0] - entry.last_bytes_low[k]};
        entry_next.last_bytes_low[k] = raw_bytes[k][31:0];
      end
      byte_limit = {32'd0, cfg.max_delta_narrow};
    end else begin
      for (int k = 0; k < 2; k++) begin
        dbytes[k] = raw_bytes[k] - entry.last_bytes[k];
      end
      byte_limit = cfg.max_delta_wide;
    end

    narrow_off = cfg.narrow_mode &&
                 ((|raw_bytes[0][63:32]) || (|raw_bytes[1][63:32]));

    over = (dbytes[0] > byte_limit) || (dbytes[1] > byte_limit) ||
           (dsmall[0] > cfg.max_delta_narrow) || (dsmall[3] > cfg.max_delta_narrow);
    acc  = entry.seen && !over;

    if (acc) begin
      for (int k = 0; k < 2; k++) begin
        entry_next.tot_bytes[k] = entry.tot_bytes[k] + dbytes[k];
      end
      for (int k = 0; k < 6; k++) begin
        entry_next.tot_small[k] = entry.tot_small[k] + dsmall[k];
      end
    end

    result.iface_out      = item.iface;
    result.total_bytes_rx = entry_next.tot_bytes[0];
    result.total_pkts_rx  = entry_next.tot_small[0];
    result.total_errs_rx  = entry_next.tot_small[1];
    result.total_drops_rx = entry_next.tot_small[2];
    result.total_bytes_tx = entry_next.tot_bytes[1];
    result.total_pkts_tx  = entry_next.tot_small[3];
    result.total_errs_tx  = entry_next.tot_small[4];
    result.total_drops_tx = entry_next.tot_small[5];
    result.discontinuity  = entry.seen && over;
    result.accumulated    = acc;
  end

endmodule

FILE: rtl/interface_counter_delta_accumulator_unit.sv
// top level of the interface counter delta accumulator
// depends on icda_pkg, the channel interfaces, icda_ram, icda_calc and assert_macros.svh
//
// usage:
//   counters carries one raw counter sample per item (interface index and the
//   eight raw counters); totals returns exactly one item per sample with the
//   running totals of that interface and the discontinuity / accumulated flags.
//   cfg writes max_delta_narrow (index 0), max_delta_wide (index 1) and
//   narrow_start (index 2, also reloads the byte counter mode); other indexes
//   are ignored. cfg is always ready; write it only while the block is idle.
// timing:
//   one item per cycle sustained while totals.ready is high; a result is registered
//   after the sample is accepted: the table ram read is registered on the accepting
//   edge with the sample; delta and totals enter the result register when s1 advances.
//   back-to-back samples of one interface are forwarded from the last write.
// reset:
//   rst is synchronous. after reset a clearing pass writes every table entry
//   to zero with counters.ready low; cfg writes are taken.
// stalls:
//   when totals.ready is low with a result pending, the result register and a
//   full in-flight stage hold and counters.ready drops until the result is taken.
`include "assert_macros.svh"

module interface_counter_delta_accumulator_unit #(
  parameter int NUM_IFACES = icda_pkg::NUM_IFACES_DEF
) (
  input logic        clk,
  input logic        rst,
  icda_in_if.sink    counters,
  icda_out_if.source totals,
  icda_cfg_if.sink   cfg
);

  localparam int AW = (NUM_IFACES > 1) ? $clog2(NUM_IFACES) : 1;
  localparam int XW = (AW > icda_pkg::IFACE_W) ? AW : icda_pkg::IFACE_W;
  localparam int EW = $bits(icda_pkg::entry_t);

  // configuration
  logic [31:0] max_delta_narrow;
  logic [63:0] max_delta_wide;
  logic        narrow_mode;
  logic        cfg_wr;
  logic        cfg_wr_narrow;

  // clearing pass
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // in-flight stage
  logic               s1_valid;
  icda_pkg::in_item_t s1_item;
  logic [AW-1:0]      s1_addr;
  logic               s1_in_range;
  logic               s1_advance;
  logic               in_accept;
  logic [XW-1:0]      iface_ext;

  // table ram and forwarding
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [EW-1:0]    ram_wdata;
  logic [EW-1:0]    ram_rdata;
  logic             byp_valid;
  logic [AW-1:0]    byp_addr;
  icda_pkg::entry_t byp_entry;
  icda_pkg::entry_t entry_cur;

  // datapath
  icda_pkg::cfg_t      calc_cfg;
  icda_pkg::entry_t    entry_next;
  icda_pkg::out_item_t calc_result;
  icda_pkg::out_item_t result;
  logic                narrow_off;

  // result register
  logic                out_valid;
  icda_pkg::out_item_t out_item;

  assign cfg.ready     = 1'b1;
  assign cfg_wr        = cfg.valid && cfg.ready;
  assign cfg_wr_narrow = cfg_wr && (cfg.index == icda_pkg::CFG_NARROW_START);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_delta_narrow <= icda_pkg::MAX_DELTA_NARROW_RST;
      max_delta_wide   <= icda_pkg::MAX_DELTA_WIDE_RST;
      narrow_mode      <= icda_pkg::NARROW_START_RST;
    end else begin
      if (cfg_wr && (cfg.index == icda_pkg::CFG_MAX_DELTA_NARROW)) begin
        max_delta_narrow <= cfg.data[31:0];
      end
      if (cfg_wr && (cfg.index == icda_pkg::CFG_MAX_DELTA_WIDE)) begin
        max_delta_wide <= cfg.data;
      end
      priority if (cfg_wr_narrow) begin
        narrow_mode <= cfg.data[0];
      end else if (s1_advance && s1_in_range && narrow_off) begin
        narrow_mode <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(NUM_IFACES - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  assign s1_advance     = s1_valid && (!out_valid || totals.ready);
  assign counters.ready = !clearing && (!s1_valid || s1_advance);
  assign in_accept      = counters.valid && counters.ready;
  assign iface_ext      = XW'(counters.item.iface);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item     <= counters.item;
      s1_addr     <= iface_ext[AW-1:0];
      s1_in_range <= 32'(counters.item.iface) < 32'(NUM_IFACES);
    end
  end

  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_advance && s1_in_range;
      ram_waddr = s1_addr;
      ram_wdata = entry_next;
    end
  end

  icda_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_IFACES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (iface_ext[AW-1:0]),
    .rdata (ram_rdata)
  );

  // the read for an item misses a write landing on the same edge,
  // so keep the last written entry and forward it on an address match
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else if (ram_we) begin
      byp_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      byp_addr  <= ram_waddr;
      byp_entry <= ram_wdata;
    end
  end

  assign entry_cur = (byp_valid && (byp_addr == s1_addr)) ? byp_entry : ram_rdata;

  always_comb begin
    calc_cfg.max_delta_narrow = max_delta_narrow;
    calc_cfg.max_delta_wide   = max_delta_wide;
    calc_cfg.narrow_mode      = narrow_mode;
  end

  icda_calc u_calc (
    .item       (s1_item),
    .entry      (entry_cur),
    .cfg        (calc_cfg),
    .entry_next (entry_next),
    .result     (calc_result),
    .narrow_off (narrow_off)
  );

  // out-of-range index: zero totals, state untouched
  always_comb begin
    if (s1_in_range) begin
      result = calc_result;
    end else begin
      result           = '0;
      result.iface_out = s1_item.iface;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (totals.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_item <= result;
    end
  end

  assign totals.valid = out_valid;
  assign totals.item  = out_item;

  `ASSERT_IMPLIES(a_clear_writes_zero, clearing, ram_we && (ram_wdata == '0), "clearing pass must write zero entries")
  `ASSERT_IMPLIES(a_narrow_rise_by_cfg, $rose(narrow_mode), $past(cfg_wr_narrow) || $past(rst), "narrow mode came back without a config write")
  `ASSERT_ALWAYS(a_flags_exclusive, !(out_valid && out_item.accumulated && out_item.discontinuity), "result flagged both accumulated and discontinuity")
  `ASSERT_NEXT(a_stage_holds, s1_valid && !s1_advance, s1_valid && $stable(s1_item) && $stable(s1_addr), "stalled in-flight item changed")

endmodule
